/* hw/rtl/btc_pkg.sv */
// Shared types and constants for the barometric temperature compensation block.
package btc_pkg;

    localparam int T_OFFSET  = 128000;
    localparam int P_BASE    = 1048576;
    localparam int P_SCALE   = 3125;
    localparam int DIV_STEPS = 64;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } calib_t;

    typedef struct packed {
        logic signed [23:0] tc;
        logic               neg;
        logic               zero;
    } div_side_t;

    typedef struct packed {
        logic signed [23:0] temperature;
        logic        [31:0] pressure;
        logic               pressure_valid;
    } result_t;

endpackage

/* hw/rtl/btc_front.sv */
// Temperature path and pressure divisor/dividend pipeline ahead of the divider.
module btc_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    adv,
    input  logic                    in_valid,
    input  logic [19:0]             raw_temp,
    input  logic [19:0]             raw_press,
    input  btc_pkg::calib_t         calib,
    output logic                    out_valid,
    output logic [63:0]             out_num,
    output logic [30:0]             out_den,
    output btc_pkg::div_side_t      out_side
);
    import btc_pkg::*;

    localparam int NSTG = 13;

    logic [NSTG-1:0] vld_reg;

    // stage 1
    logic [19:0] at_reg, ap1_reg;
    // stage 2
    logic signed [17:0] d1_reg, d2_reg;
    logic [19:0] ap2_reg;
    // stage 3
    logic signed [33:0] m1_reg;
    logic signed [35:0] m2_reg;
    logic [19:0] ap3_reg;
    // stage 4
    logic signed [22:0] v1_reg;
    logic signed [39:0] m3_reg;
    logic [19:0] ap4_reg;
    // stage 5
    logic signed [26:0] fine_reg;
    logic [19:0] ap5s_reg;
    // stage 6
    logic signed [23:0] tc6_reg;
    logic signed [26:0] a_reg;
    logic [19:0] ap6_reg;
    // stage 7
    logic signed [53:0] aa_reg;
    logic signed [42:0] ap5_reg, ap2p_reg;
    logic signed [23:0] tc7_reg;
    logic [19:0] ap7_reg;
    // stage 8
    logic [63:0] b1_reg, aa3_reg;
    logic signed [42:0] ap5b_reg, ap2b_reg;
    logic signed [23:0] tc8_reg;
    logic [19:0] ap8_reg;
    // stage 9
    logic [63:0] b_reg, x_reg;
    logic signed [23:0] tc9_reg;
    logic [19:0] ap9_reg;
    // stage 10
    logic [47:0] ppl_reg;
    logic [31:0] pph_reg;
    logic [63:0] n0_reg;
    logic signed [23:0] tc10_reg;
    // stage 11
    logic [30:0] dv_reg;
    logic [43:0] nl_reg;
    logic [31:0] nh_reg;
    logic signed [23:0] tc11_reg;
    // stage 12
    logic [63:0] n_reg;
    logic [30:0] dv12_reg;
    logic signed [23:0] tc12_reg;
    // stage 13
    logic [63:0] mn_reg;
    logic [30:0] md_reg;
    div_side_t side_reg;

    logic signed [17:0] d1_next, d2_next;
    logic signed [33:0] m1_next;
    logic signed [35:0] m2_next;
    logic signed [39:0] m3_next;
    logic signed [26:0] fine_next, a_next;
    logic signed [29:0] tm_next;
    logic signed [53:0] aa_next;
    logic signed [42:0] ap5_next, ap2_next;
    logic signed [69:0] b1_full, aa3_full;
    logic [63:0] ap5_x, ap2_x, p4_x, b_next, a2_next;
    logic [47:0] ppl_next, pph_full;
    logic [20:0] pr_next;
    logic [63:0] n0_next, xp_next, n_next;
    logic [43:0] nl_next, nh_full;

    always_comb begin
        d1_next  = $signed({1'b0, at_reg[19:3]}) - $signed({1'b0, calib.t1, 1'b0});
        d2_next  = $signed({2'b0, at_reg[19:4]}) - $signed({2'b0, calib.t1});
        m1_next  = d1_reg * $signed(calib.t2);
        m2_next  = d2_reg * d2_reg;
        m3_next  = $signed(m2_reg[35:12]) * $signed(calib.t3);
        fine_next = 27'(v1_reg) + 27'($signed(m3_reg[39:14]));
        tm_next  = 30'(fine_reg) * 30'sd5 + 30'sd128;
        a_next   = fine_reg - 27'(T_OFFSET);
        aa_next  = a_reg * a_reg;
        ap5_next = a_reg * $signed(calib.p5);
        ap2_next = a_reg * $signed(calib.p2);
        b1_full  = aa_reg * $signed(calib.p6);
        aa3_full = aa_reg * $signed(calib.p3);
        ap5_x    = 64'(ap5b_reg);
        ap2_x    = 64'(ap2b_reg);
        p4_x     = 64'($signed(calib.p4));
        b_next   = b1_reg + (ap5_x << 17) + (p4_x << 35);
        a2_next  = {{8{aa3_reg[63]}}, aa3_reg[63:8]} + (ap2_x << 12);
        ppl_next = x_reg[31:0] * calib.p1;
        pph_full = x_reg[63:32] * calib.p1;
        pr_next  = 21'(P_BASE) - {1'b0, ap9_reg};
        n0_next  = {12'd0, pr_next, 31'd0} - b_reg;
        xp_next  = {16'd0, ppl_reg} + {pph_reg, 32'd0};
        nl_next  = n0_reg[31:0] * 12'(P_SCALE);
        nh_full  = n0_reg[63:32] * 12'(P_SCALE);
        n_next   = {20'd0, nl_reg} + {nh_reg, 32'd0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            at_reg   <= raw_temp;
            ap1_reg  <= raw_press;
            d1_reg   <= d1_next;
            d2_reg   <= d2_next;
            ap2_reg  <= ap1_reg;
            m1_reg   <= m1_next;
            m2_reg   <= m2_next;
            ap3_reg  <= ap2_reg;
            v1_reg   <= $signed(m1_reg[33:11]);
            m3_reg   <= m3_next;
            ap4_reg  <= ap3_reg;
            fine_reg <= fine_next;
            ap5s_reg <= ap4_reg;
            tc6_reg  <= 24'(tm_next >>> 8);
            a_reg    <= a_next;
            ap6_reg  <= ap5s_reg;
            aa_reg   <= aa_next;
            ap5_reg  <= ap5_next;
            ap2p_reg <= ap2_next;
            tc7_reg  <= tc6_reg;
            ap7_reg  <= ap6_reg;
            b1_reg   <= b1_full[63:0];
            aa3_reg  <= aa3_full[63:0];
            ap5b_reg <= ap5_reg;
            ap2b_reg <= ap2p_reg;
            tc8_reg  <= tc7_reg;
            ap8_reg  <= ap7_reg;
            b_reg    <= b_next;
            x_reg    <= a2_next + (64'd1 << 47);
            tc9_reg  <= tc8_reg;
            ap9_reg  <= ap8_reg;
            ppl_reg  <= ppl_next;
            pph_reg  <= pph_full[31:0];
            n0_reg   <= n0_next;
            tc10_reg <= tc9_reg;
            // divisor is the product shifted down by 33, so only the top 31 bits survive
            dv_reg   <= xp_next[63:33];
            nl_reg   <= nl_next;
            nh_reg   <= nh_full[31:0];
            tc11_reg <= tc10_reg;
            n_reg    <= n_next;
            dv12_reg <= dv_reg;
            tc12_reg <= tc11_reg;
            mn_reg   <= n_reg[63] ? (64'd0 - n_reg) : n_reg;
            md_reg   <= dv12_reg[30] ? (31'd0 - dv12_reg) : dv12_reg;
            side_reg.tc   <= tc12_reg;
            side_reg.neg  <= n_reg[63] ^ dv12_reg[30];
            side_reg.zero <= (dv12_reg == 31'd0);
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign out_num   = mn_reg;
    assign out_den   = md_reg;
    assign out_side  = side_reg;

endmodule

/* hw/rtl/btc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, unsigned magnitudes.
module btc_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [63:0]         num,
    input  logic [30:0]         den,
    input  btc_pkg::div_side_t  in_side,
    output logic                out_valid,
    output logic [63:0]         quo,
    output btc_pkg::div_side_t  out_side
);
    import btc_pkg::*;

    logic [63:0] num_reg  [DIV_STEPS];
    logic [30:0] rem_reg  [DIV_STEPS];
    logic [30:0] den_reg  [DIV_STEPS];
    div_side_t   side_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] vld_reg;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [63:0] num_in;
        logic [30:0] rem_in;
        logic [30:0] den_in;
        div_side_t   side_in;
        logic        vld_in;
        logic [31:0] trial;
        logic        ge;

        if (k == 0) begin : g_first
            assign num_in  = num;
            assign rem_in  = '0;
            assign den_in  = den;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end else begin : g_next
            assign num_in  = num_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        assign trial = {rem_in, num_in[63]};
        assign ge    = (trial >= {1'b0, den_in});

        always_ff @(posedge aclk) begin
            if (adv) begin
                // shift the quotient bit in where the dividend bit left
                num_reg[k]  <= {num_in[62:0], ge};
                rem_reg[k]  <= ge ? 31'(trial - {1'b0, den_in}) : trial[30:0];
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (adv) begin
                vld_reg[k] <= vld_in;
            end
        end
    end

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign quo       = num_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];

endmodule

/* hw/rtl/btc_back.sv */
// Pressure correction terms after the division, clamping and result packing.
module btc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [63:0]         quo,
    input  btc_pkg::div_side_t  in_side,
    input  btc_pkg::calib_t     calib,
    output logic                out_valid,
    output btc_pkg::result_t    result
);
    import btc_pkg::*;

    localparam int NSTG = 6;

    logic [NSTG-1:0] vld_reg;

    logic [63:0] p1_reg, p2_reg, p3_reg, p4_reg, sum_reg;
    logic [63:0] ma_reg, sx_reg, e_reg, e3_reg, e4_reg;
    logic [63:0] ll_reg, craw_reg;
    logic [31:0] lh_reg, hl_reg;
    div_side_t   side1_reg, side2_reg, side3_reg, side4_reg, side5_reg;
    result_t     res_reg;

    logic signed [50:0] s_next;
    logic signed [66:0] ma_full;
    logic signed [79:0] e_full;
    logic [63:0] lh_full, hl_full, pf_next;
    logic [31:0] press_next;

    always_comb begin
        s_next  = $signed(p1_reg[63:13]);
        ma_full = $signed(calib.p9) * s_next;
        e_full  = $signed(calib.p8) * $signed(p1_reg);
        lh_full = ma_reg[31:0] * sx_reg[63:32];
        hl_full = ma_reg[63:32] * sx_reg[31:0];
        pf_next = {{8{sum_reg[63]}}, sum_reg[63:8]} + (64'($signed(calib.p7)) << 4);
        // clamp to the unsigned 32-bit range; a zero divisor forces zero
        if (side5_reg.zero || pf_next[63]) begin
            press_next = '0;
        end else if (|pf_next[62:32]) begin
            press_next = '1;
        end else begin
            press_next = pf_next[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_reg    <= in_side.neg ? (64'd0 - quo) : quo;
            side1_reg <= in_side;
            ma_reg    <= ma_full[63:0];
            sx_reg    <= 64'(s_next);
            e_reg     <= e_full[63:0];
            p2_reg    <= p1_reg;
            side2_reg <= side1_reg;
            ll_reg    <= ma_reg[31:0] * sx_reg[31:0];
            lh_reg    <= lh_full[31:0];
            hl_reg    <= hl_full[31:0];
            e3_reg    <= {{19{e_reg[63]}}, e_reg[63:19]};
            p3_reg    <= p2_reg;
            side3_reg <= side2_reg;
            craw_reg  <= ll_reg + {lh_reg + hl_reg, 32'd0};
            e4_reg    <= e3_reg;
            p4_reg    <= p3_reg;
            side4_reg <= side3_reg;
            sum_reg   <= p4_reg + {{25{craw_reg[63]}}, craw_reg[63:25]} + e4_reg;
            side5_reg <= side4_reg;
            res_reg.temperature    <= side5_reg.tc;
            res_reg.pressure       <= press_next;
            res_reg.pressure_valid <= !side5_reg.zero;
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign result    = res_reg;

endmodule

/* hw/rtl/baro_temp_compensation.sv */
// Top level: calibration registers, compensation pipeline and output skid stage.
//
//  channel   dir  handshake               payload
//  s_        in   s_valid / s_ready       s_raw_temp[19:0], s_raw_press[19:0]
//  m_        out  m_valid / m_ready       m_temperature[23:0], m_pressure[31:0],
//                                         m_pressure_valid
//  apb       in   psel/penable/pready     paddr[4:0], pwdata/prdata[63:0]
//
//  One transaction per cycle while the skid register is empty; 13 front stages,
//  64 divider stages, one bit each, 6 back stages, output register.
//  Reset clears all valid bits and the calibration registers.
//  A stalled result parks in a skid register; the pipeline freezes only while
//  the skid register is full.
module baro_temp_compensation (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [19:0] s_raw_temp,
    input  logic [19:0] s_raw_press,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [23:0] m_temperature,
    output logic [31:0] m_pressure,
    output logic        m_pressure_valid,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import btc_pkg::*;

    localparam logic [1:0] REG_CALIB_TEMP    = 2'd0;
    localparam logic [1:0] REG_CALIB_PRESS_A = 2'd1;
    localparam logic [1:0] REG_CALIB_PRESS_B = 2'd2;
    localparam logic [1:0] REG_CALIB_PRESS_C = 2'd3;

    logic [47:0] calib_temp_reg;
    logic [63:0] calib_press_a_reg, calib_press_b_reg;
    logic [15:0] calib_press_c_reg;
    calib_t      calib;
    logic [1:0]  reg_idx;
    logic        adv;

    logic        f_valid, d_valid, b_valid;
    logic [63:0] f_num, d_quo;
    logic [30:0] f_den;
    div_side_t   f_side, d_side;
    result_t     b_result;

    logic        m_valid_reg, skid_valid_reg;
    result_t     m_data_reg, skid_reg;

    assign reg_idx = paddr[4:3];
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calib_temp_reg    <= '0;
            calib_press_a_reg <= '0;
            calib_press_b_reg <= '0;
            calib_press_c_reg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                REG_CALIB_TEMP:    calib_temp_reg    <= pwdata[47:0];
                REG_CALIB_PRESS_A: calib_press_a_reg <= pwdata;
                REG_CALIB_PRESS_B: calib_press_b_reg <= pwdata;
                REG_CALIB_PRESS_C: calib_press_c_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_CALIB_TEMP:    prdata = {16'd0, calib_temp_reg};
            REG_CALIB_PRESS_A: prdata = calib_press_a_reg;
            REG_CALIB_PRESS_B: prdata = calib_press_b_reg;
            REG_CALIB_PRESS_C: prdata = {48'd0, calib_press_c_reg};
            default: ;
        endcase
    end

    always_comb begin
        calib.t1 = calib_temp_reg[15:0];
        calib.t2 = calib_temp_reg[31:16];
        calib.t3 = calib_temp_reg[47:32];
        calib.p1 = calib_press_a_reg[15:0];
        calib.p2 = calib_press_a_reg[31:16];
        calib.p3 = calib_press_a_reg[47:32];
        calib.p4 = calib_press_a_reg[63:48];
        calib.p5 = calib_press_b_reg[15:0];
        calib.p6 = calib_press_b_reg[31:16];
        calib.p7 = calib_press_b_reg[47:32];
        calib.p8 = calib_press_b_reg[63:48];
        calib.p9 = calib_press_c_reg;
    end

    // the whole pipeline advances unless a result is parked in the skid register
    assign adv     = !skid_valid_reg;
    assign s_ready = adv;

    btc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .raw_temp  (s_raw_temp),
        .raw_press (s_raw_press),
        .calib     (calib),
        .out_valid (f_valid),
        .out_num   (f_num),
        .out_den   (f_den),
        .out_side  (f_side)
    );

    btc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (f_valid),
        .num       (f_num),
        .den       (f_den),
        .in_side   (f_side),
        .out_valid (d_valid),
        .quo       (d_quo),
        .out_side  (d_side)
    );

    btc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (d_valid),
        .quo       (d_quo),
        .in_side   (d_side),
        .calib     (calib),
        .out_valid (b_valid),
        .result    (b_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_valid_reg && m_ready) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else if (!b_valid) begin
                m_valid_reg <= 1'b0;
            end
        end else if (!m_valid_reg) begin
            m_valid_reg <= b_valid;
        end else if (b_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_valid_reg && m_ready) begin
            m_data_reg <= skid_valid_reg ? skid_reg : b_result;
        end else if (!m_valid_reg) begin
            m_data_reg <= b_result;
        end else if (adv) begin
            skid_reg <= b_result;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_temperature    = m_data_reg.temperature;
    assign m_pressure       = m_data_reg.pressure;
    assign m_pressure_valid = m_data_reg.pressure_valid;

    a_skid_needs_output: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid register full while output register empty");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_ready && b_valid))
        else $error("skid register filled without a stalled output");

    a_invalid_zero_press: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_pressure_valid) |-> (m_pressure == 32'd0))
        else $error("pressure nonzero with zero divisor");

endmodule
